@@ hw/rtl/gld_pkg.sv @@
package gld_pkg;

  localparam int CODE_W  = 12;
  localparam int PIX_W   = 8;
  localparam int LEN_W   = 4;
  localparam int WIDTH_W = 4;
  localparam int SLOT_W  = 13;
  localparam int MCS_W   = 4;

  localparam logic [LEN_W-1:0]   LEN_SAT        = 4'd15;
  localparam logic [WIDTH_W-1:0] MAX_CODE_WIDTH = 4'd12;
  localparam logic [MCS_W-1:0]   MCS_MIN        = 4'd2;
  localparam logic [MCS_W-1:0]   MCS_MAX        = 4'd8;
  localparam logic [MCS_W-1:0]   MCS_RESET      = 4'd8;

  // One dictionary word: string length (saturating), first index, last index
  // and the code of the string without its last index.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [PIX_W-1:0]  first;
    logic [PIX_W-1:0]  suffix;
    logic [CODE_W-1:0] prefix;
  } dict_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SETUP,
    ST_WALK,
    ST_EMIT_STR,
    ST_EMIT_ONE
  } state_t;

  // Minimum code sizes outside the legal range are clamped to it.
  function automatic logic [MCS_W-1:0] eff_mcs(input logic [MCS_W-1:0] raw);
    logic [MCS_W-1:0] m;
    m = raw;
    if (m < MCS_MIN) m = MCS_MIN;
    if (m > MCS_MAX) m = MCS_MAX;
    return m;
  endfunction

endpackage

@@ hw/rtl/gld_if.sv @@
interface gld_code_if import gld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] lzw_code;

  modport source (output valid, output lzw_code, input ready);
  modport sink   (input valid, input lzw_code, output ready);
endinterface

interface gld_result_if import gld_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   palette_index;
  logic               index_valid;
  logic               last_of_code;
  logic               end_of_image;
  logic               bad_code;
  logic [WIDTH_W-1:0] next_code_width;

  modport source (output valid, output palette_index, output index_valid,
                  output last_of_code, output end_of_image, output bad_code,
                  output next_code_width, input ready);
  modport sink   (input valid, input palette_index, input index_valid,
                  input last_of_code, input end_of_image, input bad_code,
                  input next_code_width, output ready);
endinterface

@@ hw/rtl/gld_dict_ram.sv @@
module gld_dict_ram import gld_pkg::*; #(
  parameter int ENTRIES = 4096,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  dict_entry_t   wdata,
  input  logic [AW-1:0] raddr,
  output dict_entry_t   rdata
);

  dict_entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/gld_rev_stack.sv @@
module gld_rev_stack import gld_pkg::*; #(
  parameter int DEPTH = 12,
  localparam int SW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [SW-1:0]    waddr,
  input  logic [PIX_W-1:0] wdata,
  input  logic [SW-1:0]    raddr,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] slots [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      slots[waddr] <= wdata;
    end
  end

  assign rdata = slots[raddr];

endmodule

@@ hw/rtl/gif_lzw_code_decoder.sv @@
// Channel   Dir  Handshake        Payload
// codes     in   valid / ready    lzw_code[11:0]
// results   out  valid / ready    palette_index, index_valid, last_of_code,
//                                 end_of_image, bad_code, next_code_width
// cfg       in   cfg_we           cfg_data[3:0] (min_code_size)
//
// A string code of L indices (L up to MAX_STRING) is accepted, looked up in
// the dictionary twice, walked down its prefix chain with one step per index
// at one read per cycle, then sent out as L output beats; a KwKwK code needs
// one step less. Clear, end and invalid codes give a single output beat.
// Reset is synchronous; the dictionary is never cleared, since the slot
// counter keeps unwritten entries out of reach. A stalled output holds its
// register and the sequencer waits on it.
module gif_lzw_code_decoder import gld_pkg::*; #(
  parameter int DICT_ENTRIES = 4096,
  parameter int MAX_STRING   = 12
) (
  input  logic               clk,
  input  logic               rst,
  gld_code_if.sink           codes,
  gld_result_if.source       results,
  input  logic               cfg_we,
  input  logic [MCS_W-1:0]   cfg_data
);

  localparam int AW = $clog2(DICT_ENTRIES);
  localparam int SW = $clog2(MAX_STRING);
  localparam int LW = $clog2(MAX_STRING + 1);
  localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(DICT_ENTRIES);
  localparam logic [LEN_W-1:0]  MAX_LEN    = LEN_W'(MAX_STRING);

  state_t state, state_next;

  logic [MCS_W-1:0]   min_code_size;
  logic [SLOT_W-1:0]  next_free_slot;
  logic [WIDTH_W-1:0] code_width;
  logic [CODE_W-1:0]  previous_code;
  logic               after_clear;

  logic [CODE_W-1:0]  code_reg;
  logic               is_kwk;
  logic [LEN_W-1:0]   plen;
  logic [PIX_W-1:0]   pfirst;
  logic               one_eoi;
  logic               one_bad;
  logic [LW-1:0]      str_len;
  logic               trunc;
  logic [SW-1:0]      walk_pos;
  logic [CODE_W-1:0]  walk_node;
  logic [SW-1:0]      emit_idx;

  logic               out_valid;
  logic [PIX_W-1:0]   out_pal;
  logic               out_pix;
  logic               out_last;
  logic               out_eoi;
  logic               out_bad;
  logic [WIDTH_W-1:0] out_width;

  // Dictionary and stack ports.
  logic [CODE_W-1:0]  rd_code;
  dict_entry_t        rd_entry;
  logic               dict_we;
  dict_entry_t        new_entry;
  logic               stk_we;
  logic [SW-1:0]      stk_waddr;
  logic [PIX_W-1:0]   stk_wdata;
  logic [PIX_W-1:0]   stk_rdata;

  // Decode of the current code.
  logic [MCS_W-1:0]   mcs_eff;
  logic [CODE_W-1:0]  clear_code;
  logic [CODE_W-1:0]  end_code;
  logic [SLOT_W-1:0]  code_slot;
  logic               table_open;
  logic               kwk_now;
  logic               code_ok;
  logic               code_root;
  logic               prev_root;
  logic               is_clear;
  logic               is_end;
  logic [LEN_W-1:0]   p_len;
  logic [PIX_W-1:0]   p_first;
  logic [LEN_W-1:0]   plen_inc;
  logic [LEN_W-1:0]   cur_len;
  logic [PIX_W-1:0]   cur_first;
  logic               cur_trunc;
  logic [LW-1:0]      cur_l;
  logic [SW-1:0]      start_pos;
  logic [SLOT_W-1:0]  slot_inc;
  logic               widen;
  logic               node_root;
  logic [PIX_W-1:0]   walk_val;
  logic [CODE_W-1:0]  walk_next;
  logic               slot_free;
  logic               last_idx;
  logic [MCS_W-1:0]   restart_mcs;
  logic [SLOT_W-1:0]  restart_slot;
  logic [WIDTH_W-1:0] restart_width;

  gld_dict_ram #(.ENTRIES(DICT_ENTRIES)) u_dict (
    .clk   (clk),
    .we    (dict_we),
    .waddr (next_free_slot[AW-1:0]),
    .wdata (new_entry),
    .raddr (rd_code[AW-1:0]),
    .rdata (rd_entry)
  );

  gld_rev_stack #(.DEPTH(MAX_STRING)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (emit_idx),
    .rdata (stk_rdata)
  );

  always_comb begin
    mcs_eff    = eff_mcs(min_code_size);
    clear_code = CODE_W'(1) << mcs_eff;
    end_code   = clear_code + CODE_W'(1);
    code_slot  = {1'b0, code_reg};
    table_open = next_free_slot < SLOT_LIMIT;
    is_clear   = code_reg == clear_code;
    is_end     = code_reg == end_code;
    code_root  = code_reg < clear_code;
    prev_root  = previous_code < clear_code;
    // The KwKwK code is the slot about to be filled.
    kwk_now    = (code_slot == next_free_slot) && !after_clear && table_open;
    code_ok    = code_root || (code_reg > end_code && code_slot < next_free_slot) ||
                 kwk_now;

    // Lookup of the previous code; the read data belongs to it in ST_LOOK.
    p_len   = prev_root ? LEN_W'(1) : rd_entry.len;
    p_first = prev_root ? previous_code[PIX_W-1:0] : rd_entry.first;

    // Lookup of the current code; the read data belongs to it in ST_SETUP.
    plen_inc  = (plen == LEN_SAT) ? LEN_SAT : plen + LEN_W'(1);
    cur_len   = is_kwk ? plen_inc : (code_root ? LEN_W'(1) : rd_entry.len);
    cur_first = is_kwk ? pfirst : (code_root ? code_reg[PIX_W-1:0] : rd_entry.first);
    cur_trunc = cur_len > MAX_LEN;
    if (cur_trunc) begin
      cur_l = LW'(MAX_STRING);
    end else if (cur_len == '0) begin
      cur_l = LW'(1);
    end else begin
      cur_l = LW'(cur_len);
    end
    start_pos = is_kwk ? SW'(cur_l - LW'(2)) : SW'(cur_l - LW'(1));

    new_entry = '{len: plen_inc, first: pfirst, suffix: cur_first, prefix: previous_code};
    slot_inc  = next_free_slot + SLOT_W'(1);
    widen     = (code_width < MAX_CODE_WIDTH) &&
                (slot_inc == (SLOT_W'(1) << code_width)) && (slot_inc < SLOT_LIMIT);
    dict_we   = (state == ST_SETUP) && !after_clear && table_open;

    // One step down the prefix chain; a root ends the chain.
    node_root = walk_node < clear_code;
    walk_val  = node_root ? walk_node[PIX_W-1:0] : rd_entry.suffix;
    walk_next = node_root ? '0 : rd_entry.prefix;

    slot_free = !out_valid || results.ready;
    last_idx  = emit_idx == SW'(str_len - LW'(1));

    restart_mcs   = cfg_we ? eff_mcs(cfg_data) : mcs_eff;
    restart_slot  = (SLOT_W'(1) << restart_mcs) + SLOT_W'(2);
    restart_width = WIDTH_W'(restart_mcs) + WIDTH_W'(1);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_code    = previous_code;
    stk_we     = 1'b0;
    stk_waddr  = walk_pos;
    stk_wdata  = walk_val;
    unique case (state)
      ST_IDLE: begin
        rd_code = previous_code;
        if (codes.valid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        rd_code = code_reg;
        if (is_clear || is_end || !code_ok) begin
          state_next = ST_EMIT_ONE;
        end else begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        rd_code = is_kwk ? previous_code : code_reg;
        // The KwKwK string ends in the first index of the previous string.
        stk_we    = is_kwk;
        stk_waddr = SW'(cur_l - LW'(1));
        stk_wdata = pfirst;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        rd_code = walk_next;
        stk_we  = 1'b1;
        if (walk_pos == '0) begin
          state_next = ST_EMIT_STR;
        end
      end
      ST_EMIT_STR: begin
        if (slot_free && last_idx) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_ONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign codes.ready = (state == ST_IDLE) && !rst;

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_code_size  <= MCS_RESET;
      next_free_slot <= (SLOT_W'(1) << MCS_RESET) + SLOT_W'(2);
      code_width     <= WIDTH_W'(MCS_RESET) + WIDTH_W'(1);
      previous_code  <= '0;
      after_clear    <= 1'b1;
    end else if (cfg_we || (state == ST_LOOK && is_clear)) begin
      if (cfg_we) begin
        min_code_size <= cfg_data;
      end
      next_free_slot <= restart_slot;
      code_width     <= restart_width;
      previous_code  <= '0;
      after_clear    <= 1'b1;
    end else if (state == ST_SETUP) begin
      if (dict_we) begin
        next_free_slot <= slot_inc;
        if (widen) begin
          code_width <= code_width + WIDTH_W'(1);
        end
      end
      previous_code <= code_reg;
      after_clear   <= 1'b0;
    end
  end

  // Per-code working registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (codes.valid) begin
          code_reg <= codes.lzw_code;
        end
      end
      ST_LOOK: begin
        is_kwk  <= kwk_now;
        plen    <= p_len;
        pfirst  <= p_first;
        one_eoi <= is_end;
        one_bad <= !is_clear && !is_end && !code_ok;
      end
      ST_SETUP: begin
        str_len   <= cur_l;
        trunc     <= cur_trunc;
        walk_pos  <= start_pos;
        walk_node <= is_kwk ? previous_code : code_reg;
        emit_idx  <= '0;
      end
      ST_WALK: begin
        walk_pos  <= walk_pos - SW'(1);
        walk_node <= walk_next;
      end
      ST_EMIT_STR: begin
        if (slot_free) begin
          emit_idx <= emit_idx + SW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_EMIT_STR || state == ST_EMIT_ONE) && slot_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (state == ST_EMIT_STR) begin
        out_pal   <= stk_rdata;
        out_pix   <= 1'b1;
        out_last  <= last_idx;
        out_eoi   <= 1'b0;
        out_bad   <= trunc;
        out_width <= code_width;
      end else if (state == ST_EMIT_ONE) begin
        out_pal   <= '0;
        out_pix   <= 1'b0;
        out_last  <= 1'b1;
        out_eoi   <= one_eoi;
        out_bad   <= one_bad;
        out_width <= code_width;
      end
    end
  end

  assign results.valid           = out_valid;
  assign results.palette_index   = out_pal;
  assign results.index_valid     = out_pix;
  assign results.last_of_code    = out_last;
  assign results.end_of_image    = out_eoi;
  assign results.bad_code        = out_bad;
  assign results.next_code_width = out_width;

  // Only the final beat of a code can be a non-pixel beat.
  a_mid_beat_is_pixel: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.last_of_code |-> results.index_valid)
    else $error("non-final beat without a pixel");

  a_end_beat_form: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.end_of_image |->
      results.last_of_code && !results.index_valid && !results.bad_code)
    else $error("end-of-image beat malformed");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    next_free_slot <= SLOT_LIMIT)
    else $error("free slot beyond dictionary");

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    code_width >= WIDTH_W'(3) && code_width <= MAX_CODE_WIDTH)
    else $error("code width out of range");

  a_slot_grows_by_one: assert property (@(posedge clk) disable iff (rst)
    state == ST_SETUP && !cfg_we && dict_we |=> next_free_slot == $past(slot_inc))
    else $error("slot counter did not advance by one");

endmodule
